>>> rtl/bpe_pkg.sv
package bpe_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
   localparam int CFG_W   = 11;
   localparam int PIXEL_W = 8;
   localparam int POS_W   = 10;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1024);

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               edge_res;
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] center;
      logic [PIXEL_W-1:0] down;
      logic [PIXEL_W-1:0] left;
      logic               up_ok;
      logic               right_ok;
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic               last;
   } stage_type;

   function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
      logic [WID_W-1:0] result;
      if (v == '0) begin
         result = WID_W'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         result = WID_W'(MAX_WIDTH);
      end else begin
         result = WID_W'(v);
      end
      return result;
   endfunction

   function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
      logic [HGT_W-1:0] result;
      if (v == '0) begin
         result = HGT_W'(1);
      end else if (32'(v) > MAX_HEIGHT) begin
         result = HGT_W'(MAX_HEIGHT);
      end else begin
         result = HGT_W'(v);
      end
      return result;
   endfunction

endpackage

>>> rtl/bpe_if.sv
interface bpe_req_if import bpe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               action;

   modport source (output valid, pixel, action, input ready);
   modport sink   (input valid, pixel, action, output ready);
endinterface

interface bpe_rsp_if import bpe_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             edge_res;
   logic [POS_W-1:0] x;
   logic [POS_W-1:0] y;
   logic             last;

   modport source (output valid, edge_res, x, y, last, input ready);
   modport sink   (input valid, edge_res, x, y, last, output ready);
endinterface

>>> rtl/boundary_pixel_extract_top.sv
// Four-neighbour boundary marker for an 8-bit gray image sent in raster order.
// The req_chan channel takes one item per pixel (pixel, action); after the last
// image row the host sends one row of drain items, which stand for zero pixels
// below the frame. The rsp_chan channel returns edge_res with the column x, the
// row y and a last flag on the final result of the frame. Results lag one row:
// the item at row r, column c gives the result for pixel (r-1, c), and items of
// the first row give none.
// Throughput is one item per clock cycle while the queue has room. Each result
// goes via s1 and the queue; the two line stores are read and written at the
// edge that accepts the item, and their read data is used in the cycle after.
// Results wait in a four-entry output queue. When the receiver stalls, the queue
// fills and req_chan.ready falls; nothing is dropped.
// The csr port sets image_width (index 0) and image_height (index 1); write them
// only while the block is idle. Synchronous reset clears the counters and the
// queue and restores both sizes to 1024; the line stores are not cleared, and
// the block accepts an item in the first cycle after reset.
module boundary_pixel_extract_top import bpe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bpe_req_if.sink          req_chan,
   bpe_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0]      width_ff, width_in;
   logic [CFG_W-1:0]      height_ff, height_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [HGT_W-1:0]      row_ff, row_in;
   logic [PIXEL_W-1:0]    first_down_ff, first_down_in;
   logic [PIXEL_W-1:0]    left_ff, left_in;
   logic                  s1_valid_ff, s1_valid_in;
   stage_type             s1_ff, s1_in;
   rsp_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   logic [WID_W-1:0]   w_eff;
   logic [HGT_W-1:0]   h_eff;
   logic [WID_W-1:0]   col_next;
   logic               accept, pop, end_of_row, end_of_frame;
   logic [PIXEL_W-1:0] down, center, left_val;
   logic [PIXEL_W-1:0] above_rdata, two_above_rdata;
   logic [PIXEL_W-1:0] up_val, right_val, all_and;
   rsp_type            result;

   assign w_eff        = clamp_width(width_ff);
   assign h_eff        = clamp_height(height_ff);
   assign col_next     = WID_W'(col_ff) + WID_W'(1);
   assign end_of_row   = (col_next >= w_eff);
   assign end_of_frame = (row_ff >= h_eff);

   assign req_chan.ready = (count_ff + FIFO_CNT_W'(s1_valid_ff)) < FIFO_CNT_W'(FIFO_DEPTH);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   assign down     = (req_chan.action || end_of_frame) ? '0 : req_chan.pixel;
   assign center   = (col_ff == '0) ? first_down_ff : above_rdata;
   assign left_val = (col_ff == '0) ? '0 : left_ff;

   bpe_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_above_ram (
      .clock (clock),
      .we    (accept),
      .waddr (col_ff),
      .wdata (down),
      .re    (accept),
      .raddr (col_next[COL_W-1:0]),
      .rdata (above_rdata)
   );

   bpe_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_two_above_ram (
      .clock (clock),
      .we    (accept),
      .waddr (col_ff),
      .wdata (center),
      .re    (accept),
      .raddr (col_ff),
      .rdata (two_above_rdata)
   );

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      first_down_in = first_down_ff;
      left_in       = left_ff;
      s1_valid_in   = 1'b0;
      s1_in         = s1_ff;
      if (accept) begin
         left_in = center;
         if (col_ff == '0) begin
            first_down_in = down;
         end
         if (end_of_row) begin
            col_in = '0;
            row_in = end_of_frame ? '0 : row_ff + HGT_W'(1);
         end else begin
            col_in = col_next[COL_W-1:0];
         end
         s1_valid_in    = (row_ff != '0);
         s1_in.center   = center;
         s1_in.down     = down;
         s1_in.left     = left_val;
         s1_in.up_ok    = (row_ff >= HGT_W'(2));
         s1_in.right_ok = !end_of_row;
         s1_in.x        = POS_W'(col_ff);
         s1_in.y        = POS_W'(row_ff - HGT_W'(1));
         s1_in.last     = end_of_frame && end_of_row;
      end
   end

   always_comb begin
      up_val          = s1_ff.up_ok ? two_above_rdata : '0;
      right_val       = s1_ff.right_ok ? above_rdata : '0;
      all_and         = up_val & s1_ff.down & s1_ff.left & right_val;
      result.edge_res = (s1_ff.center != '0) && (all_and == '0);
      result.x        = s1_ff.x;
      result.y        = s1_ff.y;
      result.last     = s1_ff.last;
   end

   always_comb begin
      wr_ptr_in = s1_valid_ff ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(s1_valid_ff) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         first_down_ff <= '0;
         left_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         first_down_ff <= first_down_in;
         left_ff       <= left_in;
         s1_valid_ff   <= s1_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (s1_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_chan.valid    = (count_ff != '0);
   assign rsp_chan.edge_res = fifo_ff[rd_ptr_ff].edge_res;
   assign rsp_chan.x        = fifo_ff[rd_ptr_ff].x;
   assign rsp_chan.y        = fifo_ff[rd_ptr_ff].y;
   assign rsp_chan.last     = fifo_ff[rd_ptr_ff].last;

endmodule

>>> rtl/bpe_ram.sv
module bpe_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/bpe_checker.sv
module bpe_checker import bpe_pkg::*; (
   input logic       clock,
   input logic       reset,
   bpe_req_if.sink   req_chan,
   bpe_rsp_if.source rsp_chan
);

   // A held item keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.edge_res)
         && $stable(rsp_chan.x) && $stable(rsp_chan.y) && $stable(rsp_chan.last))
      else $error("result item changed while stalled");

   // Reset empties the queue and leaves room for a new item.
   assert property (@(posedge clock) reset |=> !rsp_chan.valid && req_chan.ready)
      else $error("block not empty and ready after reset");

   // A result can only appear in an empty queue once a taken item has passed s1.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(req_chan.valid && req_chan.ready, 2))
      else $error("result item without an accepted input item");

   // The last result of a frame closes its row, so the next result starts a row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last |=>
         !rsp_chan.valid || rsp_chan.x == '0)
      else $error("result after end of frame does not start a row");

endmodule

bind boundary_pixel_extract_top bpe_checker u_bpe_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
